// ===== design/gps_rmc_sentence_parser_core_defines.svh =====
`ifndef GPS_RMC_SENTENCE_PARSER_CORE_DEFINES_SVH
`define GPS_RMC_SENTENCE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off while in reset
`define GPSRMC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GPSRMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/gpsrmc_pkg.sv =====
`default_nettype none

package gpsrmc_pkg;

   localparam int FRAC_DIGITS     = 4;
   localparam int MAX_FIELD_CHARS = 14;

   localparam int BYTE_W  = 8;
   localparam int ACC_W   = 28;
   localparam int LAT_W   = 27;
   localparam int LON_W   = 28;
   localparam int SPEED_W = 24;
   localparam int CHARS_W = 4;
   localparam int FRAC_CNT_W = $clog2(FRAC_DIGITS + 1);

   function automatic longint unsigned pow10(input int n);
      longint unsigned r;
      r = 1;
      for (int i = 0; i < n; i++) begin
         r = r * 10;
      end
      return r;
   endfunction

   function automatic longint unsigned cap_at(input longint unsigned v,
                                              input longint unsigned c);
      return (v > c) ? c : v;
   endfunction

   localparam longint unsigned POW_FRAC = pow10(FRAC_DIGITS);
   localparam int SCALE_W = $clog2(POW_FRAC + 1);

   localparam logic [ACC_W-1:0]   ACC_CAP     = '1;
   localparam logic [LAT_W-1:0]   LAT_LIMIT   =
      LAT_W'(cap_at(64'd9000 * POW_FRAC, (64'd1 << LAT_W) - 64'd1));
   localparam logic [LON_W-1:0]   LON_LIMIT   =
      LON_W'(cap_at(64'd18000 * POW_FRAC, (64'd1 << LON_W) - 64'd1));
   localparam logic [SPEED_W-1:0] SPEED_LIMIT = 24'd9999999;
   localparam logic [CHARS_W-1:0] CHARS_SAT   = '1;

   // header match position; HDR_DONE means inside a sentence
   localparam logic [2:0] HDR_IDLE = 3'd0;
   localparam logic [2:0] HDR_DONE = 3'd7;

   // field index = commas seen after the header
   localparam logic [2:0] FLD_TIME   = 3'd0;
   localparam logic [2:0] FLD_STATUS = 3'd1;
   localparam logic [2:0] FLD_LAT    = 3'd2;
   localparam logic [2:0] FLD_NS     = 3'd3;
   localparam logic [2:0] FLD_LON    = 3'd4;
   localparam logic [2:0] FLD_EW     = 3'd5;
   localparam logic [2:0] FLD_SPEED  = 3'd6;

   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_POINT  = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_E      = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_N      = 8'h4E;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } byte_beat_type;

   // "$GPRMC,"
   function automatic logic [BYTE_W-1:0] hdr_char(input logic [2:0] pos);
      logic [BYTE_W-1:0] c;
      case (pos)
         3'd0:    c = CHAR_DOLLAR;
         3'd1:    c = 8'h47;
         3'd2:    c = 8'h50;
         3'd3:    c = 8'h52;
         3'd4:    c = 8'h4D;
         3'd5:    c = 8'h43;
         3'd6:    c = CHAR_COMMA;
         default: c = '0;
      endcase
      return c;
   endfunction

   // 10^k for k in 0..FRAC_DIGITS
   function automatic logic [SCALE_W-1:0] scale_of(input logic [FRAC_CNT_W-1:0] k);
      logic [SCALE_W-1:0] r;
      r = '0;
      for (int i = 0; i <= FRAC_DIGITS; i++) begin
         if (k == FRAC_CNT_W'(i)) r = SCALE_W'(pow10(i));
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/gpsrmc_if.sv =====
`default_nettype none

interface gpsrmc_req_if import gpsrmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gpsrmc_rsp_if import gpsrmc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               fix_valid;
   logic [LAT_W-1:0]   latitude_ddmm;
   logic [LON_W-1:0]   longitude_dddmm;
   logic               is_north;
   logic               is_east;
   logic [SPEED_W-1:0] speed_knots;
   logic               field_overflow;

   modport source (output valid, output fix_valid, output latitude_ddmm,
                   output longitude_dddmm, output is_north, output is_east,
                   output speed_knots, output field_overflow, input ready);
   modport sink   (input valid, input fix_valid, input latitude_ddmm,
                   input longitude_dddmm, input is_north, input is_east,
                   input speed_knots, input field_overflow, output ready);
endinterface

`default_nettype wire

// ===== design/gpsrmc_in_stage.sv =====
`default_nettype none

module gpsrmc_in_stage import gpsrmc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   gpsrmc_req_if.sink    req,
   input  logic          take,
   output byte_beat_type beat
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              load;

   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      valid_in = load ? 1'b1 : (valid_ff && !take);
      data_in  = load ? req.rx_byte : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

`default_nettype wire

// ===== design/gpsrmc_parser.sv =====
`default_nettype none
`include "gps_rmc_sentence_parser_core_defines.svh"

module gpsrmc_parser import gpsrmc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  byte_beat_type beat,
   output logic          take,
   gpsrmc_rsp_if.source  rsp
);

   logic [2:0]            hdr_ff, hdr_in;
   logic [2:0]            comma_ff, comma_in;
   logic [BYTE_W-1:0]     status_ff, status_in;
   logic                  north_ff, north_in;
   logic                  east_ff, east_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [FRAC_CNT_W-1:0] frac_ff, frac_in;
   logic                  point_ff, point_in;
   logic                  ended_ff, ended_in;
   logic [CHARS_W-1:0]    chars_ff, chars_in;
   logic [LAT_W-1:0]      pend_lat_ff, pend_lat_in;
   logic [LON_W-1:0]      pend_lon_ff, pend_lon_in;
   logic [LAT_W-1:0]      held_lat_ff, held_lat_in;
   logic [LON_W-1:0]      held_lon_ff, held_lon_in;
   logic                  ovf_ff, ovf_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_fix_ff, out_fix_in;
   logic [LAT_W-1:0]      out_lat_ff, out_lat_in;
   logic [LON_W-1:0]      out_lon_ff, out_lon_in;
   logic                  out_north_ff, out_north_in;
   logic                  out_east_ff, out_east_in;
   logic [SPEED_W-1:0]    out_speed_ff, out_speed_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic [BYTE_W-1:0]        rx;
   logic                     is_digit;
   logic [ACC_W+3:0]         push_sum;
   logic                     push_sat;
   logic [SCALE_W-1:0]       fin_scale;
   logic [ACC_W+SCALE_W-1:0] fin_prod;
   logic                     fin_sat;
   logic [ACC_W-1:0]         fin_raw;
   logic [ACC_W-1:0]         fin_limit;
   logic                     fin_over;
   logic [ACC_W-1:0]         fin_value;
   logic                     fin_ovf;
   logic                     fix;
   logic                     emit;
   logic                     emit_load;

   assign take      = beat.valid && (!out_valid_ff || rsp.ready);
   assign rx        = beat.data;
   assign is_digit  = rx inside {[CHAR_ZERO:CHAR_NINE]};
   assign emit_load = take && emit;
   assign fix       = (status_ff == CHAR_A);

   // acc * 10 + digit, saturating
   assign push_sum = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + (ACC_W+4)'(rx - CHAR_ZERO);
   assign push_sat = push_sum > {4'b0, ACC_CAP};

   // pad missing fraction digits, then clamp to the field range
   assign fin_scale = scale_of(FRAC_CNT_W'(FRAC_DIGITS) - frac_ff);
   assign fin_prod  = acc_ff * fin_scale;
   assign fin_sat   = fin_prod > (ACC_W+SCALE_W)'(ACC_CAP);
   assign fin_raw   = fin_sat ? ACC_CAP : fin_prod[ACC_W-1:0];

   always_comb begin
      case (comma_ff)
         FLD_LAT: fin_limit = ACC_W'(LAT_LIMIT);
         FLD_LON: fin_limit = ACC_W'(LON_LIMIT);
         default: fin_limit = ACC_W'(SPEED_LIMIT);
      endcase
   end

   assign fin_over  = fin_raw > fin_limit;
   assign fin_value = fin_over ? fin_limit : fin_raw;
   assign fin_ovf   = fin_sat || fin_over;

   always_comb begin
      hdr_in      = hdr_ff;
      comma_in    = comma_ff;
      status_in   = status_ff;
      north_in    = north_ff;
      east_in     = east_ff;
      acc_in      = acc_ff;
      frac_in     = frac_ff;
      point_in    = point_ff;
      ended_in    = ended_ff;
      chars_in    = chars_ff;
      pend_lat_in = pend_lat_ff;
      pend_lon_in = pend_lon_ff;
      held_lat_in = held_lat_ff;
      held_lon_in = held_lon_ff;
      ovf_in      = ovf_ff;
      emit        = 1'b0;

      if (take) begin
         if (hdr_ff != HDR_DONE) begin
            if (rx == hdr_char(hdr_ff)) begin
               hdr_in = hdr_ff + 3'd1;
            end else if (rx == CHAR_DOLLAR) begin
               hdr_in = 3'd1;
            end else begin
               hdr_in = HDR_IDLE;
            end
            if (hdr_in == HDR_DONE) begin
               comma_in  = FLD_TIME;
               chars_in  = '0;
               ovf_in    = 1'b0;
               status_in = '0;
               acc_in    = '0;
               frac_in   = '0;
               point_in  = 1'b0;
               ended_in  = 1'b0;
            end
         end else if (rx == CHAR_COMMA) begin
            comma_in = comma_ff + 3'd1;
            chars_in = '0;
            acc_in   = '0;
            frac_in  = '0;
            point_in = 1'b0;
            ended_in = 1'b0;
            case (comma_ff)
               FLD_TIME: begin
                  status_in = '0;
               end
               FLD_LAT: begin
                  pend_lat_in = fin_value[LAT_W-1:0];
                  ovf_in      = ovf_ff || fin_ovf;
                  north_in    = 1'b0;
               end
               FLD_LON: begin
                  pend_lon_in = fin_value[LON_W-1:0];
                  ovf_in      = ovf_ff || fin_ovf;
                  east_in     = 1'b0;
               end
               FLD_SPEED: begin
                  emit     = 1'b1;
                  ovf_in   = ovf_ff || fin_ovf;
                  hdr_in   = HDR_IDLE;
                  comma_in = FLD_TIME;
                  if (fix) begin
                     held_lat_in = pend_lat_ff;
                     held_lon_in = pend_lon_ff;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            if (chars_ff != CHARS_SAT) chars_in = chars_ff + 1'b1;
            case (comma_ff)
               FLD_STATUS: begin
                  if (chars_ff == '0) status_in = rx;
               end
               FLD_NS: begin
                  if (chars_ff == '0) north_in = (rx == CHAR_N);
               end
               FLD_EW: begin
                  if (chars_ff == '0) east_in = (rx == CHAR_E);
               end
               FLD_LAT, FLD_LON, FLD_SPEED: begin
                  if (chars_ff >= CHARS_W'(MAX_FIELD_CHARS)) ovf_in = 1'b1;
                  if (!ended_ff) begin
                     if (is_digit) begin
                        if (!point_ff || frac_ff < FRAC_CNT_W'(FRAC_DIGITS)) begin
                           acc_in = push_sat ? ACC_CAP : push_sum[ACC_W-1:0];
                           if (push_sat) ovf_in = 1'b1;
                           if (point_ff) frac_in = frac_ff + 1'b1;
                        end
                     end else if (rx == CHAR_POINT && !point_ff) begin
                        point_in = 1'b1;
                     end else begin
                        ended_in = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      out_valid_in = emit_load ? 1'b1 : (out_valid_ff && !rsp.ready);
      out_fix_in   = out_fix_ff;
      out_lat_in   = out_lat_ff;
      out_lon_in   = out_lon_ff;
      out_north_in = out_north_ff;
      out_east_in  = out_east_ff;
      out_speed_in = out_speed_ff;
      out_ovf_in   = out_ovf_ff;
      if (emit_load) begin
         out_fix_in   = fix;
         out_lat_in   = held_lat_in;
         out_lon_in   = held_lon_in;
         out_north_in = north_ff;
         out_east_in  = east_ff;
         out_speed_in = fin_value[SPEED_W-1:0];
         out_ovf_in   = ovf_ff || fin_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= HDR_IDLE;
         comma_ff     <= FLD_TIME;
         status_ff    <= '0;
         north_ff     <= 1'b0;
         east_ff      <= 1'b0;
         acc_ff       <= '0;
         frac_ff      <= '0;
         point_ff     <= 1'b0;
         ended_ff     <= 1'b0;
         chars_ff     <= '0;
         pend_lat_ff  <= '0;
         pend_lon_ff  <= '0;
         held_lat_ff  <= '0;
         held_lon_ff  <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hdr_ff       <= hdr_in;
         comma_ff     <= comma_in;
         status_ff    <= status_in;
         north_ff     <= north_in;
         east_ff      <= east_in;
         acc_ff       <= acc_in;
         frac_ff      <= frac_in;
         point_ff     <= point_in;
         ended_ff     <= ended_in;
         chars_ff     <= chars_in;
         pend_lat_ff  <= pend_lat_in;
         pend_lon_ff  <= pend_lon_in;
         held_lat_ff  <= held_lat_in;
         held_lon_ff  <= held_lon_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      out_fix_ff   <= out_fix_in;
      out_lat_ff   <= out_lat_in;
      out_lon_ff   <= out_lon_in;
      out_north_ff <= out_north_in;
      out_east_ff  <= out_east_in;
      out_speed_ff <= out_speed_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.fix_valid       = out_fix_ff;
   assign rsp.latitude_ddmm   = out_lat_ff;
   assign rsp.longitude_dddmm = out_lon_ff;
   assign rsp.is_north        = out_north_ff;
   assign rsp.is_east         = out_east_ff;
   assign rsp.speed_knots     = out_speed_ff;
   assign rsp.field_overflow  = out_ovf_ff;

   `GPSRMC_ASSERT_NEXT(a_emit_rearms_hunt, emit_load, (hdr_ff == HDR_IDLE) && (comma_ff == FLD_TIME), "sentence end did not rearm header hunt")
   `GPSRMC_ASSERT_NOW(a_stall_blocks_parse, out_valid_ff && !rsp.ready, !take, "byte parsed while result beat stalled")
   `GPSRMC_ASSERT_NEXT(a_held_only_on_fix, !(emit_load && fix), $stable(held_lat_ff) && $stable(held_lon_ff), "held position moved without a valid fix")
   `GPSRMC_ASSERT_NOW(a_speed_capped, out_valid_ff, out_speed_ff <= SPEED_LIMIT, "speed beyond limit")

endmodule

`default_nettype wire

// ===== design/gps_rmc_sentence_parser_core.sv =====
// Path: an accepted req beat is held in the input register, and the rsp beat it completes in the output register.
// Throughput: one byte per cycle while no result beat stalls; a result beat may wait in its
// output register while the next byte is taken into the input register.
// A stalled result holds the parser, and with it the input register.
// Reset: synchronous, active high; clears the header hunt, field state and held fix.
`default_nettype none

module gps_rmc_sentence_parser_core import gpsrmc_pkg::*; (
   input logic          clock,
   input logic          reset,
   gpsrmc_req_if.sink   req_chan,
   gpsrmc_rsp_if.source rsp_chan
);

   byte_beat_type beat;
   logic          take;

   gpsrmc_in_stage u_in_stage (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .take  (take),
      .beat  (beat)
   );

   gpsrmc_parser u_parser (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .take  (take),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire
